/* src/mtm_pkg.sv */
// ----------------------------------------------------------------------------
// mtm_pkg
// Types and codes shared by the membership table merge block.
// ----------------------------------------------------------------------------
package mtm_pkg;

  localparam int unsigned IdW  = 64;
  localparam int unsigned CtrW = 16;

  localparam logic [1:0] ModeUp     = 2'd0;
  localparam logic [1:0] ModeDown   = 2'd1;
  localparam logic [1:0] ModeGossip = 2'd2;
  localparam logic [1:0] ModeUnused = 2'd3;

  localparam logic [1:0] StDirect   = 2'd0;
  localparam logic [1:0] StIndirect = 2'd1;
  localparam logic [1:0] StDead     = 2'd2;
  localparam logic [1:0] StUnused   = 2'd3;

  localparam logic [2:0] OutSame     = 3'd0;
  localparam logic [2:0] OutInserted = 3'd1;
  localparam logic [2:0] OutUpdated  = 3'd2;
  localparam logic [2:0] OutRefute   = 3'd3;
  localparam logic [2:0] OutUnknown  = 3'd4;
  localparam logic [2:0] OutFull     = 3'd5;

  localparam logic [1:0] RegSelfHigh = 2'd0;
  localparam logic [1:0] RegSelfLow  = 2'd1;

  typedef struct packed {
    logic [IdW-1:0]         id_high;
    logic [IdW-1:0]         id_low;
    logic signed [CtrW-1:0] counter;
    logic [1:0]             state;
  } entry_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

/* src/mtm_store.sv */
// ----------------------------------------------------------------------------
// mtm_store
// Member table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mtm_store #(
  parameter int unsigned TABLE_DEPTH = 64,
  localparam int unsigned AddrW = $clog2(TABLE_DEPTH)
) (
  input  logic                clk_i,
  input  mtm_pkg::mem_ctl_t   ctl_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  mtm_pkg::entry_t     wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output mtm_pkg::entry_t     rdata_o
);

  mtm_pkg::entry_t mem_q [TABLE_DEPTH];
  mtm_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/mtm_ctrl.sv */
// ----------------------------------------------------------------------------
// mtm_ctrl
// Request sequencer: scans the table for the id, merges, writes back.
// ----------------------------------------------------------------------------
module mtm_ctrl #(
  parameter int unsigned TABLE_DEPTH = 64,
  localparam int unsigned AddrW = $clog2(TABLE_DEPTH),
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           mode_i,
  input  logic [mtm_pkg::IdW-1:0]              member_id_high_i,
  input  logic [mtm_pkg::IdW-1:0]              member_id_low_i,
  input  logic signed [mtm_pkg::CtrW-1:0]      reported_counter_i,
  input  logic [1:0]                           reported_state_i,
  input  logic [mtm_pkg::IdW-1:0]              self_id_high_i,
  input  logic [mtm_pkg::IdW-1:0]              self_id_low_i,
  output mtm_pkg::mem_ctl_t                    mem_ctl_o,
  output logic [AddrW-1:0]                     mem_waddr_o,
  output mtm_pkg::entry_t                      mem_wdata_o,
  output logic [AddrW-1:0]                     mem_raddr_o,
  input  mtm_pkg::entry_t                      mem_rdata_i,
  output logic                                 done_o,
  output logic [2:0]                           outcome_o,
  output logic                                 regossip_o,
  output logic [1:0]                           forward_state_o,
  output logic signed [mtm_pkg::CtrW-1:0]      forward_counter_o,
  output logic signed [mtm_pkg::CtrW-1:0]      refute_counter_o,
  output logic                                 restart_timer_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                          state_q;
  logic [1:0]                      mode_q;
  logic [mtm_pkg::IdW-1:0]         hi_q;
  logic [mtm_pkg::IdW-1:0]         lo_q;
  logic signed [mtm_pkg::CtrW-1:0] ctr_q;
  logic [1:0]                      rs_q;
  logic                            ign_q;
  logic [CntW-1:0]                 idx_q;
  logic [CntW-1:0]                 count_q;
  logic                            rd_vld_q;
  logic [AddrW-1:0]                rd_addr_q;
  logic                            done_q;
  logic [2:0]                      outcome_q;
  logic                            regossip_q;
  logic [1:0]                      fstate_q;
  logic signed [mtm_pkg::CtrW-1:0] fctr_q;
  logic signed [mtm_pkg::CtrW-1:0] refute_q;
  logic                            timer_q;

  logic                            accept;
  logic                            hit;
  logic                            miss;
  logic                            finish;
  logic                            full;
  logic                            is_self;
  logic                            re;
  logic                            we;
  logic [AddrW-1:0]                waddr;
  mtm_pkg::entry_t                 wentry;
  logic                            count_inc;
  logic [2:0]                      outcome_d;
  logic                            regossip_d;
  logic                            timer_d;
  logic signed [mtm_pkg::CtrW-1:0] refute_d;
  logic [1:0]                      rs_norm;

  assign accept  = start && (state_q == ST_IDLE);
  assign hit     = rd_vld_q && (mem_rdata_i.id_high == hi_q) && (mem_rdata_i.id_low == lo_q);
  assign miss    = !rd_vld_q && (idx_q == count_q);
  assign finish  = (state_q == ST_SCAN) && (ign_q || hit || miss);
  assign full    = (count_q == CntW'(TABLE_DEPTH));
  assign is_self = (hi_q == self_id_high_i) && (lo_q == self_id_low_i);
  assign re      = (state_q == ST_SCAN) && !finish && (idx_q < count_q);
  assign rs_norm = (reported_state_i == mtm_pkg::StDirect) ? mtm_pkg::StIndirect
                                                           : reported_state_i;

  always_comb begin
    we          = 1'b0;
    waddr       = rd_addr_q;
    wentry      = mem_rdata_i;
    count_inc   = 1'b0;
    outcome_d   = mtm_pkg::OutSame;
    regossip_d  = 1'b0;
    timer_d     = 1'b0;
    refute_d    = '0;
    if (!ign_q) begin
      if (!hit) begin
        wentry.id_high = hi_q;
        wentry.id_low  = lo_q;
        wentry.counter = ctr_q;
        wentry.state   = (mode_q == mtm_pkg::ModeUp) ? mtm_pkg::StDirect : rs_q;
        waddr          = count_q[AddrW-1:0];
        if (mode_q == mtm_pkg::ModeDown) begin
          outcome_d = mtm_pkg::OutUnknown;
        end else if (full) begin
          outcome_d = mtm_pkg::OutFull;
        end else begin
          we         = 1'b1;
          count_inc  = 1'b1;
          outcome_d  = mtm_pkg::OutInserted;
          regossip_d = (mode_q == mtm_pkg::ModeGossip);
        end
        timer_d = (mode_q == mtm_pkg::ModeUp);
      end else begin
        unique case (mode_q)
          mtm_pkg::ModeUp: begin
            timer_d = 1'b1;
            if (mem_rdata_i.counter < ctr_q) begin
              wentry.counter = ctr_q;
              wentry.state   = mtm_pkg::StDirect;
              we             = 1'b1;
              outcome_d      = mtm_pkg::OutUpdated;
            end else if (mem_rdata_i.counter == ctr_q &&
                         mem_rdata_i.state == mtm_pkg::StIndirect) begin
              wentry.state = mtm_pkg::StDirect;
              we           = 1'b1;
              outcome_d    = mtm_pkg::OutUpdated;
            end
          end
          mtm_pkg::ModeDown: begin
            timer_d = 1'b1;
            if (mem_rdata_i.state != mtm_pkg::StDead) begin
              wentry.state = mtm_pkg::StDead;
              we           = 1'b1;
              outcome_d    = mtm_pkg::OutUpdated;
            end
          end
          default: begin
            if (is_self && rs_q == mtm_pkg::StDead) begin
              outcome_d = mtm_pkg::OutRefute;
              refute_d  = ctr_q;
            end else if (mem_rdata_i.counter == ctr_q && rs_q == mtm_pkg::StDead &&
                         mem_rdata_i.state != mtm_pkg::StDead) begin
              wentry.state = mtm_pkg::StDead;
              we           = 1'b1;
              outcome_d    = mtm_pkg::OutUpdated;
              regossip_d   = 1'b1;
            end else if (mem_rdata_i.counter < ctr_q) begin
              wentry.counter = ctr_q;
              wentry.state   = rs_q;
              we             = 1'b1;
              outcome_d      = mtm_pkg::OutUpdated;
              regossip_d     = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q  <= ST_SCAN;
            mode_q   <= mode_i;
            hi_q     <= member_id_high_i;
            lo_q     <= member_id_low_i;
            ctr_q    <= reported_counter_i;
            rs_q     <= rs_norm;
            ign_q    <= (mode_i == mtm_pkg::ModeUnused) ||
                        (mode_i == mtm_pkg::ModeGossip &&
                         reported_state_i == mtm_pkg::StUnused);
            idx_q    <= '0;
            rd_vld_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          rd_vld_q <= re;
          if (re) begin
            rd_addr_q <= idx_q[AddrW-1:0];
            idx_q     <= idx_q + 1'b1;
          end
          if (finish) begin
            state_q    <= ST_IDLE;
            done_q     <= 1'b1;
            outcome_q  <= outcome_d;
            regossip_q <= regossip_d;
            fstate_q   <= regossip_d ? rs_q : 2'd0;
            fctr_q     <= regossip_d ? ctr_q : '0;
            refute_q   <= refute_d;
            timer_q    <= timer_d;
            if (count_inc) begin
              count_q <= count_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy              = (state_q != ST_IDLE);
  assign mem_ctl_o.we      = finish && we;
  assign mem_ctl_o.re      = re;
  assign mem_waddr_o       = waddr;
  assign mem_wdata_o       = wentry;
  assign mem_raddr_o       = idx_q[AddrW-1:0];
  assign done_o            = done_q;
  assign outcome_o         = outcome_q;
  assign regossip_o        = regossip_q;
  assign forward_state_o   = fstate_q;
  assign forward_counter_o = fctr_q;
  assign refute_counter_o  = refute_q;
  assign restart_timer_o   = timer_q;

endmodule

/* src/membership_table_merge.sv */
// ----------------------------------------------------------------------------
// membership_table_merge
// Gossip membership table with incarnation counter merge.
//
// Usage:
//   Input: drive the event fields and raise start; the request is taken at
//   a rising edge with start high and busy low. Exactly one result follows,
//   shown for one cycle with done_o high; the receiver cannot stall it.
//   Configuration: cfg_valid_i / cfg_ready_o write self_id_high (index 0)
//   or self_id_low (index 1); write only while busy is low and no result
//   is pending. cfg_ready_o is always high.
//   Scan: the table is scanned one entry per cycle out of a memory with
//   registered read data. done_o rises once the id matches or the last
//   stored member has been read (at once for an ignored request);
//   busy falls in the same cycle, so the next request can be taken then.
//   A new request is taken only after the previous result has been shown.
//   Reset: the table empties at once (fill count cleared) and both self id
//   registers read zero.
// ----------------------------------------------------------------------------
module membership_table_merge #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           mode_i,
  input  logic [mtm_pkg::IdW-1:0]              member_id_high_i,
  input  logic [mtm_pkg::IdW-1:0]              member_id_low_i,
  input  logic signed [mtm_pkg::CtrW-1:0]      reported_counter_i,
  input  logic [1:0]                           reported_state_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [1:0]                           cfg_index_i,
  input  logic [mtm_pkg::IdW-1:0]              cfg_data_i,
  output logic                                 done_o,
  output logic [2:0]                           outcome_o,
  output logic                                 regossip_o,
  output logic [1:0]                           forward_state_o,
  output logic signed [mtm_pkg::CtrW-1:0]      forward_counter_o,
  output logic signed [mtm_pkg::CtrW-1:0]      refute_counter_o,
  output logic                                 restart_timer_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  logic [mtm_pkg::IdW-1:0] self_id_high_q;
  logic [mtm_pkg::IdW-1:0] self_id_low_q;
  mtm_pkg::mem_ctl_t       mem_ctl;
  logic [AddrW-1:0]        mem_waddr;
  logic [AddrW-1:0]        mem_raddr;
  mtm_pkg::entry_t         mem_wdata;
  mtm_pkg::entry_t         mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_id_high_q <= '0;
      self_id_low_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mtm_pkg::RegSelfHigh: self_id_high_q <= cfg_data_i;
        mtm_pkg::RegSelfLow:  self_id_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mtm_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .mode_i             (mode_i),
    .member_id_high_i   (member_id_high_i),
    .member_id_low_i    (member_id_low_i),
    .reported_counter_i (reported_counter_i),
    .reported_state_i   (reported_state_i),
    .self_id_high_i     (self_id_high_q),
    .self_id_low_i      (self_id_low_q),
    .mem_ctl_o          (mem_ctl),
    .mem_waddr_o        (mem_waddr),
    .mem_wdata_o        (mem_wdata),
    .mem_raddr_o        (mem_raddr),
    .mem_rdata_i        (mem_rdata),
    .done_o             (done_o),
    .outcome_o          (outcome_o),
    .regossip_o         (regossip_o),
    .forward_state_o    (forward_state_o),
    .forward_counter_o  (forward_counter_o),
    .refute_counter_o   (refute_counter_o),
    .restart_timer_o    (restart_timer_o)
  );

  mtm_store #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request taken without going busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && !$past(done_o))
    else $error("result strobe while busy or repeated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !(outcome_o == mtm_pkg::OutInserted || outcome_o == mtm_pkg::OutUpdated)
      |-> !regossip_o)
    else $error("regossip without a table change");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.we |-> busy)
    else $error("table write outside a request");

endmodule
